FILE: hdl/rcpd_pkg.sv
// Shared types and constants of the receiver core.
package rcpd_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int HOP_SLOTS    = 20;
    localparam int MAX_MISSED   = 15;

    localparam int CH_STORE     = 8;
    localparam int SLOT_W       = 5;
    localparam int MISS_W       = $clog2(MAX_MISSED + 2);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DIVN_W       = 19;
    localparam int DIVQ_W       = 16;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_PACKET = 2'd1;
    localparam logic [1:0] FUNC_HOP    = 2'd2;

    localparam logic [1:0] MODE_4CH = 2'd1;
    localparam logic [1:0] MODE_8CH = 2'd2;

    localparam logic [1:0] CFG_PROTOCOL_MODE  = 2'd0;
    localparam logic [1:0] CFG_SERVO_CENTER   = 2'd1;
    localparam logic [1:0] CFG_FAILSAFE_TICKS = 2'd2;

    localparam logic [1:0] STATUS_IDLE      = 2'd0;
    localparam logic [1:0] STATUS_RECEIVING = 2'd1;
    localparam logic [1:0] STATUS_FAILSAFE  = 2'd2;

    localparam logic [7:0] ID_STICK_3CH = 8'h55;
    localparam logic [7:0] ID_STICK_4CH = 8'h56;
    localparam logic [7:0] ID_STICK_8CH = 8'h57;
    localparam logic [7:0] ID_FS_3CH    = 8'haa;
    localparam logic [7:0] ID_FS_4CH    = 8'hab;
    localparam logic [7:0] ID_FS_8CH    = 8'hac;
    localparam logic [7:0] FS_ENABLE    = 8'h5a;

    localparam logic [5:0]  LEN_8CH            = 6'd13;
    localparam logic [15:0] TX_BIAS            = 16'hf200;
    localparam logic [15:0] FULL_SCALE         = 16'hffff;
    localparam logic [15:0] OFFSET_8CH         = 16'(476 * 2);
    localparam logic [15:0] SERVO_CENTER_RST   = 16'd1500;
    localparam logic [15:0] FAILSAFE_TICKS_RST = 16'd64;

    // floor(2^22 / 7): quotient estimate is low by at most one
    localparam int          RECIP_SHIFT = 22;
    localparam logic [19:0] RECIP_7     = 20'd599186;
    localparam logic [DIVN_W-1:0] DIV_7 = DIVN_W'(7);

    typedef logic [15:0] word_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_HOP,
        CMD_CLR_MISS,
        CMD_STICK4,
        CMD_FS4_SET,
        CMD_FS4_OFF,
        CMD_STICK8,
        CMD_FS8
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        word_t [CH_STORE-1:0]     vals;
        word_t                    raw_b;
        logic [DIVN_W-1:0]        div_num;
        logic [DIVQ_W-1:0]        div_q0;
        logic                     div_neg;
    } cmd_t;

    typedef struct packed {
        word_t servo_center;
        word_t failsafe_ticks;
    } back_cfg_t;

endpackage

FILE: hdl/rcpd_front.sv
// Event classifier: decodes one event into a command for the back end.
module rcpd_front (
    input  logic [1:0]          func,
    input  logic [63:0]         payload_low,
    input  logic [39:0]         payload_high,
    input  logic [5:0]          payload_length,
    input  logic [1:0]          protocol_mode,
    output rcpd_pkg::cmd_t      cmd
);
    import rcpd_pkg::*;

    logic [103:0]             pl;
    logic [7:0]               pb [13];
    logic [7:0]               sid;
    logic [7:0]               fid;
    logic [15:0]              s_word;
    logic [15:0]              mag;
    logic [DIVN_W-1:0]        num;
    logic [38:0]              prod;
    word_t [CH_STORE-1:0]     vals4;
    word_t [CH_STORE-1:0]     vals8;
    logic [3:0]               nib;

    assign pl = {payload_high, payload_low};

    always_comb
    begin
        for (int k = 0; k < 13; k++)
        begin
            pb[k] = pl[8*k +: 8];
        end
    end

    always_comb
    begin
        vals4    = '0;
        vals4[0] = FULL_SCALE - {pb[1], pb[0]};
        vals4[1] = FULL_SCALE - {pb[3], pb[2]};
        vals4[2] = FULL_SCALE - {pb[5], pb[4]};
        vals4[3] = FULL_SCALE - {pb[9], pb[6]};
        for (int i = 0; i < CH_STORE; i++)
        begin
            nib      = pb[9 + (i >> 1)][4*(i & 1) +: 4];
            vals8[i] = OFFSET_8CH + {4'd0, nib, pb[1 + i]};
        end
    end

    assign s_word = {pb[5], pb[4]};
    assign mag    = (s_word < TX_BIAS) ? (TX_BIAS - s_word) : (s_word - TX_BIAS);
    assign num    = DIVN_W'({mag, 2'b00}) + DIVN_W'(mag);
    assign prod   = 39'(num) * 39'(RECIP_7);

    assign sid = (protocol_mode == MODE_4CH) ? ID_STICK_4CH : ID_STICK_3CH;
    assign fid = (protocol_mode == MODE_4CH) ? ID_FS_4CH : ID_FS_3CH;

    always_comb
    begin
        cmd.vals    = (protocol_mode == MODE_8CH) ? vals8 : vals4;
        cmd.raw_b   = {pb[6], pb[9]};
        cmd.div_num = num;
        cmd.div_q0  = prod[RECIP_SHIFT +: DIVQ_W];
        cmd.div_neg = (s_word < TX_BIAS);
        cmd.kind    = CMD_NONE;
        case (func)
            FUNC_TICK:
            begin
                cmd.kind = CMD_TICK;
            end
            FUNC_HOP:
            begin
                cmd.kind = CMD_HOP;
            end
            FUNC_PACKET:
            begin
                if (protocol_mode == MODE_8CH)
                begin
                    if (payload_length == LEN_8CH)
                    begin
                        if (pb[0] == ID_STICK_8CH)
                        begin
                            cmd.kind = CMD_STICK8;
                        end
                        else if (pb[0] == ID_FS_8CH)
                        begin
                            cmd.kind = CMD_FS8;
                        end
                        else
                        begin
                            cmd.kind = CMD_CLR_MISS;
                        end
                    end
                end
                else if (pb[7] == sid)
                begin
                    cmd.kind = CMD_STICK4;
                end
                else if (pb[7] == fid)
                begin
                    cmd.kind = (pb[8] == FS_ENABLE) ? CMD_FS4_SET : CMD_FS4_OFF;
                end
                else
                begin
                    cmd.kind = CMD_CLR_MISS;
                end
            end
            default:
            begin
                cmd.kind = CMD_NONE;
            end
        endcase
    end

endmodule

FILE: hdl/rcpd_queue.sv
// Short command queue between the classifier and the executor.
module rcpd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcpd_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output rcpd_pkg::cmd_t  pop_data,
    output logic            empty
);
    import rcpd_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/rcpd_back.sv
// Command executor: link supervision, channel and failsafe state, hop tracking.
module rcpd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcpd_pkg::back_cfg_t  cfg,
    input  rcpd_pkg::cmd_t       cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          channels_low,
    output logic [63:0]          channels_high,
    output logic [15:0]          raw_word_a,
    output logic [15:0]          raw_word_b,
    output logic [1:0]           link_status,
    output logic                 outputs_enabled,
    output logic [4:0]           hop_slot,
    output logic                 hop_restart,
    output logic                 failsafe_armed
);
    import rcpd_pkg::*;

    word_t               chan_reg  [CH_STORE];
    word_t               chan_next [CH_STORE];
    word_t               fs_reg    [CH_STORE];
    word_t               fs_next   [CH_STORE];
    logic                fs_on_reg;
    logic                fs_on_next;
    word_t               tmo_reg;
    word_t               tmo_next;
    logic                seen_reg;
    logic                seen_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [MISS_W-1:0]   miss_reg;
    logic [MISS_W-1:0]   miss_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    word_t               raw_a_reg;
    word_t               raw_a_next;
    word_t               raw_b_reg;
    word_t               raw_b_next;
    logic                restart_reg;
    logic                restart_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                fire;
    logic [MISS_W-1:0]   miss_inc;
    logic [DIVN_W-1:0]   rem;
    logic [DIVQ_W-1:0]   quot;
    word_t               raw_a_calc;

    assign fire    = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop = fire;

    // finish the divide by seven: the estimate is low by at most one
    assign rem        = cmd.div_num - DIVN_W'(cmd.div_q0) * DIV_7;
    assign quot       = cmd.div_q0 + DIVQ_W'(rem >= DIV_7);
    assign raw_a_calc = cmd.div_neg ? (16'd0 - 16'(quot)) : 16'(quot);
    assign miss_inc   = miss_reg + 1'b1;

    always_comb
    begin
        for (int i = 0; i < CH_STORE; i++)
        begin
            chan_next[i] = chan_reg[i];
            fs_next[i]   = fs_reg[i];
        end
        fs_on_next     = fs_on_reg;
        tmo_next       = tmo_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        miss_next      = miss_reg;
        slot_next      = slot_reg;
        raw_a_next     = raw_a_reg;
        raw_b_next     = raw_b_reg;
        restart_next   = restart_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            restart_next   = 1'b0;
            if (cmd.kind == CMD_TICK && tmo_reg != '0)
            begin
                tmo_next = tmo_reg - 1'b1;
            end
            if (seen_reg && tmo_next == '0)
            begin
                for (int i = 0; i < CH_STORE; i++)
                begin
                    if (i < NUM_CHANNELS)
                    begin
                        chan_next[i] = fs_reg[i];
                    end
                end
                status_next = STATUS_FAILSAFE;
            end
            case (cmd.kind)
                CMD_HOP:
                begin
                    if (miss_inc > MISS_W'(MAX_MISSED))
                    begin
                        miss_next    = '0;
                        slot_next    = '0;
                        restart_next = 1'b1;
                    end
                    else
                    begin
                        miss_next = miss_inc;
                        slot_next = (slot_reg == SLOT_W'(HOP_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                    end
                end
                CMD_CLR_MISS:
                begin
                    miss_next = '0;
                end
                CMD_STICK4:
                begin
                    miss_next = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        chan_next[i] = cmd.vals[i];
                    end
                    raw_a_next  = raw_a_calc;
                    raw_b_next  = cmd.raw_b;
                    seen_next   = 1'b1;
                    tmo_next    = cfg.failsafe_ticks;
                    status_next = STATUS_RECEIVING;
                end
                CMD_FS4_SET:
                begin
                    miss_next  = '0;
                    fs_on_next = 1'b1;
                    for (int i = 0; i < 4; i++)
                    begin
                        fs_next[i] = cmd.vals[i];
                    end
                end
                CMD_FS4_OFF:
                begin
                    miss_next  = '0;
                    fs_on_next = 1'b0;
                    tmo_next   = cfg.failsafe_ticks;
                    for (int i = 0; i < CH_STORE; i++)
                    begin
                        if (i < NUM_CHANNELS)
                        begin
                            fs_next[i] = cfg.servo_center;
                        end
                    end
                end
                CMD_STICK8:
                begin
                    miss_next = '0;
                    for (int i = 0; i < CH_STORE; i++)
                    begin
                        if (i < NUM_CHANNELS)
                        begin
                            chan_next[i] = cmd.vals[i];
                        end
                    end
                    seen_next   = 1'b1;
                    tmo_next    = cfg.failsafe_ticks;
                    status_next = STATUS_RECEIVING;
                end
                CMD_FS8:
                begin
                    miss_next  = '0;
                    fs_on_next = 1'b1;
                    for (int i = 0; i < CH_STORE; i++)
                    begin
                        if (i < NUM_CHANNELS)
                        begin
                            fs_next[i] = cmd.vals[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_STORE; i++)
            begin
                chan_reg[i] <= '0;
                fs_reg[i]   <= SERVO_CENTER_RST;
            end
            fs_on_reg     <= 1'b0;
            tmo_reg       <= FAILSAFE_TICKS_RST;
            seen_reg      <= 1'b0;
            status_reg    <= STATUS_IDLE;
            miss_reg      <= '0;
            slot_reg      <= '0;
            raw_a_reg     <= '0;
            raw_b_reg     <= '0;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < CH_STORE; i++)
            begin
                chan_reg[i] <= chan_next[i];
                fs_reg[i]   <= fs_next[i];
            end
            fs_on_reg     <= fs_on_next;
            tmo_reg       <= tmo_next;
            seen_reg      <= seen_next;
            status_reg    <= status_next;
            miss_reg      <= miss_next;
            slot_reg      <= slot_next;
            raw_a_reg     <= raw_a_next;
            raw_b_reg     <= raw_b_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign channels_low    = {chan_reg[3], chan_reg[2], chan_reg[1], chan_reg[0]};
    assign channels_high   = {chan_reg[7], chan_reg[6], chan_reg[5], chan_reg[4]};
    assign raw_word_a      = raw_a_reg;
    assign raw_word_b      = raw_b_reg;
    assign link_status     = status_reg;
    assign outputs_enabled = seen_reg;
    assign hop_slot        = slot_reg;
    assign hop_restart     = restart_reg;
    assign failsafe_armed  = fs_on_reg;

endmodule

FILE: hdl/rc_packet_decoder_failsafe_hop_core.sv
// Top level of the radio-control receiver core.
//
// Input channel (in_valid/in_ready): one event per transaction, tick, packet
// or hop-timer expiry, with the packet bytes and length. Every event yields
// exactly one result transaction on the output channel (out_valid/out_ready)
// carrying the channel values, raw words and link/hop status after the event.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 protocol
// mode, 1 servo center, 2 failsafe ticks; other indexes are ignored. Write it
// only while no events are in flight.
// A transaction taken enters the command queue, is executed once the output
// stage can accept a result, and its result is presented from then on.
// Throughput: one event per cycle while results are taken; the classifier
// feeds a two-entry command queue and the executor retires one command per
// cycle into the output stage. When the receiver stalls, the result holds,
// the executor stops, and in_ready drops once the queue holds two commands.
// Reset: channels zero, failsafe values 1500, timeout 64, status idle,
// hop slot zero, registers at their defaults; no events pending.
module rc_packet_decoder_failsafe_hop_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   func,
    input  logic [63:0]  payload_low,
    input  logic [39:0]  payload_high,
    input  logic [5:0]   payload_length,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  channels_low,
    output logic [63:0]  channels_high,
    output logic [15:0]  raw_word_a,
    output logic [15:0]  raw_word_b,
    output logic [1:0]   link_status,
    output logic         outputs_enabled,
    output logic [4:0]   hop_slot,
    output logic         hop_restart,
    output logic         failsafe_armed
);
    import rcpd_pkg::*;

    logic [1:0]  mode_reg;
    word_t       center_reg;
    word_t       ticks_reg;
    back_cfg_t   back_cfg;
    cmd_t        front_cmd;
    cmd_t        queue_cmd;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        push;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd0;
            center_reg <= SERVO_CENTER_RST;
            ticks_reg  <= FAILSAFE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PROTOCOL_MODE:
                begin
                    mode_reg <= cfg_data[1:0];
                end
                CFG_SERVO_CENTER:
                begin
                    center_reg <= cfg_data;
                end
                CFG_FAILSAFE_TICKS:
                begin
                    ticks_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign back_cfg.servo_center   = center_reg;
    assign back_cfg.failsafe_ticks = ticks_reg;

    rcpd_front u_front (
        .func           (func),
        .payload_low    (payload_low),
        .payload_high   (payload_high),
        .payload_length (payload_length),
        .protocol_mode  (mode_reg),
        .cmd            (front_cmd)
    );

    rcpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (queue_cmd),
        .empty     (q_empty)
    );

    rcpd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (back_cfg),
        .cmd             (queue_cmd),
        .cmd_valid       (!q_empty),
        .cmd_pop         (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .channels_low    (channels_low),
        .channels_high   (channels_high),
        .raw_word_a      (raw_word_a),
        .raw_word_b      (raw_word_b),
        .link_status     (link_status),
        .outputs_enabled (outputs_enabled),
        .hop_slot        (hop_slot),
        .hop_restart     (hop_restart),
        .failsafe_armed  (failsafe_armed)
    );

    a_status_needs_stick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outputs_enabled || link_status == STATUS_IDLE))
        else $error("link active before any stick transaction");

    a_restart_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hop_restart) |-> (hop_slot == '0))
        else $error("hop restart with nonzero slot");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hop_slot < SLOT_W'(HOP_SLOTS)))
        else $error("hop slot out of range");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

endmodule
